/* rtl/core/bps_pkg.sv */
// ----------------------------------------------------------------------------
// bps_pkg
// Shared widths and register index codes for the byte pattern search block.
// ----------------------------------------------------------------------------
package bps_pkg;

  localparam int unsigned PATTERN_W    = 64;
  localparam int unsigned LEN_CFG_W    = 4;
  localparam int unsigned ADDR_W       = 64;
  localparam int unsigned OFFSET_OUT_W = 32;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned CFG_IDX_W    = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PATTERN_VALUE  = 2'd0,
    CFG_PATTERN_LENGTH = 2'd1,
    CFG_REGION_BASE    = 2'd2
  } cfg_idx_e;

endpackage

/* rtl/core/bps_window.sv */
// ----------------------------------------------------------------------------
// bps_window
// Input stage: history window, byte counter and the registered compare snapshot.
// ----------------------------------------------------------------------------
module bps_window #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                end_of_region_i,
  output logic                                s1_valid_o,
  input  logic                                s1_ready_i,
  output logic [MAX_PATTERN_BYTES-1:0][7:0]   s1_bytes_o,
  output logic [OFFSET_BITS-1:0]              s1_pos_o
);

  logic                              accept;
  logic                              s1_valid_q, s1_valid_d;
  logic [MAX_PATTERN_BYTES-1:0][7:0] s1_bytes_q, s1_bytes_d;
  logic [OFFSET_BITS-1:0]            s1_pos_q;
  logic [OFFSET_BITS-1:0]            cnt_q, cnt_d;

  assign in_stall_o = s1_valid_q & ~s1_ready_i;
  assign accept     = in_valid_i & ~in_stall_o;

  // count restarts after the region's last byte, saturates at all ones
  always_comb begin
    cnt_d = cnt_q;
    if (accept) begin
      if (end_of_region_i) begin
        cnt_d = '0;
      end else if (cnt_q != '1) begin
        cnt_d = cnt_q + 1'b1;
      end
    end
  end

  if (MAX_PATTERN_BYTES > 1) begin : g_hist
    localparam int unsigned WinD = MAX_PATTERN_BYTES - 1;
    logic [WinD-1:0][7:0] win_q, win_d;

    always_comb begin
      win_d = win_q;
      if (accept) begin
        if (end_of_region_i) begin
          win_d = '0;
        end else begin
          win_d[0] = data_byte_i;
          for (int k = 1; k < WinD; k++) begin
            win_d[k] = win_q[k-1];
          end
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        win_q <= '0;
      end else begin
        win_q <= win_d;
      end
    end

    assign s1_bytes_d = {win_q, data_byte_i};
  end else begin : g_no_hist
    assign s1_bytes_d = data_byte_i;
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_ready_i) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      cnt_q      <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      cnt_q      <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_bytes_q <= s1_bytes_d;
      s1_pos_q   <= cnt_q;
    end
  end

  assign s1_valid_o = s1_valid_q;
  assign s1_bytes_o = s1_bytes_q;
  assign s1_pos_o   = s1_pos_q;

  a_hold_snapshot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q && !s1_ready_i |=> s1_valid_q && $stable(s1_pos_q))
    else $error("stalled snapshot lost or changed");

  a_region_restart: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && end_of_region_i |=> cnt_q == '0)
    else $error("byte count not cleared after last byte");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !end_of_region_i && cnt_q != '1 |=>
      cnt_q == OFFSET_BITS'($past(cnt_q) + 1'b1))
    else $error("byte count did not advance");

endmodule

/* rtl/core/bps_match.sv */
// ----------------------------------------------------------------------------
// bps_match
// Result stage: parallel window compare, offset/address math, result register.
// ----------------------------------------------------------------------------
module bps_match #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned OFFSET_BITS       = 32,
  localparam int unsigned LenW = $clog2(MAX_PATTERN_BYTES + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s1_valid_i,
  output logic                                s1_ready_o,
  input  logic [MAX_PATTERN_BYTES-1:0][7:0]   s1_bytes_i,
  input  logic [OFFSET_BITS-1:0]              s1_pos_i,
  input  logic [bps_pkg::PATTERN_W-1:0]       pattern_i,
  input  logic [LenW-1:0]                     len_i,
  input  logic [bps_pkg::ADDR_W-1:0]          base_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bps_pkg::OFFSET_OUT_W-1:0]    start_offset_o,
  output logic [bps_pkg::ADDR_W-1:0]          match_address_o
);

  localparam int unsigned IdxW = (MAX_PATTERN_BYTES > 1) ? $clog2(MAX_PATTERN_BYTES) : 1;

  logic [MAX_PATTERN_BYTES-1:0] byte_ok;
  logic [bps_pkg::ADDR_W-1:0]   pos_inc, start;
  logic                         enough, hit, take;
  logic                         res_valid_q, res_valid_d;
  logic [bps_pkg::OFFSET_OUT_W-1:0] res_offset_q;
  logic [bps_pkg::ADDR_W-1:0]   res_addr_q;

  // pattern byte i lines up with the byte len-1-i positions back
  for (genvar i = 0; i < MAX_PATTERN_BYTES; i++) begin : g_cmp
    logic [LenW-1:0] lag;
    logic [7:0]      pat_b;
    logic [7:0]      win_b;

    assign lag   = len_i - LenW'(i) - LenW'(1);
    assign win_b = s1_bytes_i[lag[IdxW-1:0]];
    if (i < 8) begin : g_pat
      assign pat_b = pattern_i[i*8 +: 8];
    end else begin : g_zero
      assign pat_b = 8'h00;
    end
    assign byte_ok[i] = (LenW'(i) >= len_i) || (win_b == pat_b);
  end

  assign pos_inc = bps_pkg::ADDR_W'(s1_pos_i) + 1'b1;
  assign enough  = pos_inc >= bps_pkg::ADDR_W'(len_i);
  assign start   = pos_inc - bps_pkg::ADDR_W'(len_i);
  assign hit     = enough & (&byte_ok);

  assign s1_ready_o = ~res_valid_q | ~out_stall_i;
  assign take       = s1_valid_i & s1_ready_o;

  always_comb begin
    res_valid_d = res_valid_q;
    if (take) begin
      res_valid_d = hit;
    end else if (!out_stall_i) begin
      res_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && hit) begin
      res_offset_q <= start[bps_pkg::OFFSET_OUT_W-1:0];
      res_addr_q   <= base_i + start;
    end
  end

  assign out_valid_o     = res_valid_q;
  assign start_offset_o  = res_offset_q;
  assign match_address_o = res_addr_q;

  a_no_false_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && !hit |=> !res_valid_q)
    else $error("result raised without a match");

endmodule

/* rtl/core/byte_pattern_search.sv */
// ----------------------------------------------------------------------------
// byte_pattern_search
// Sliding-window exact pattern match over a byte stream with region offsets.
// ----------------------------------------------------------------------------
// Pipeline: a byte is held in the snapshot register, then a hit in the result
//   register. Throughput: one byte per cycle unless in_stall_o is raised; the
//   whole window compare is one parallel level of byte comparators between them.
// Reset: window, byte count and pipeline valids clear; pattern_value and
//   region_base read zero, pattern_length reads 4 (clamped to the max).
// ----------------------------------------------------------------------------
module byte_pattern_search #(
  parameter int unsigned MAX_PATTERN_BYTES = 8,
  parameter int unsigned OFFSET_BITS       = 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [bps_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [bps_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // byte requests
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [7:0]                          data_byte_i,
  input  logic                                end_of_region_i,
  // match requests
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [bps_pkg::OFFSET_OUT_W-1:0]    start_offset_o,
  output logic [bps_pkg::ADDR_W-1:0]          match_address_o
);

  localparam int unsigned LenW = $clog2(MAX_PATTERN_BYTES + 1);
  // reset length of 4, clamped to what the window supports
  localparam int unsigned LenRst = (MAX_PATTERN_BYTES < 4) ? MAX_PATTERN_BYTES : 4;

  logic [bps_pkg::PATTERN_W-1:0]   pattern_q;
  logic [LenW-1:0]                 len_q, len_d;
  logic [bps_pkg::ADDR_W-1:0]      base_q;
  logic [bps_pkg::LEN_CFG_W-1:0]   len_raw;

  logic                              s1_valid, s1_ready;
  logic [MAX_PATTERN_BYTES-1:0][7:0] s1_bytes;
  logic [OFFSET_BITS-1:0]            s1_pos;

  // Clamp the length once at write time: zero acts as one, anything past
  // the window size acts as the window size.
  assign len_raw = cfg_data_i[bps_pkg::LEN_CFG_W-1:0];

  always_comb begin
    if (len_raw == '0) begin
      len_d = LenW'(1);
    end else if (8'(len_raw) > 8'(MAX_PATTERN_BYTES)) begin
      len_d = LenW'(MAX_PATTERN_BYTES);
    end else begin
      len_d = LenW'(len_raw);
    end
  end

  // Register file; writes must land only while the pipeline is drained (the user's
  // duty, not enforced by the block), as the compare stage reads these directly.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q <= '0;
      len_q     <= LenW'(LenRst);
      base_q    <= '0;
    end else if (cfg_we_i) begin
      unique case (bps_pkg::cfg_idx_e'(cfg_idx_i))
        bps_pkg::CFG_PATTERN_VALUE:  pattern_q <= cfg_data_i;
        bps_pkg::CFG_PATTERN_LENGTH: len_q     <= len_d;
        bps_pkg::CFG_REGION_BASE:    base_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Stage 1: shift the byte into the history and snapshot the full window
  // together with the byte's offset in the region.
  bps_window #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_window (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .end_of_region_i (end_of_region_i),
    .s1_valid_o      (s1_valid),
    .s1_ready_i      (s1_ready),
    .s1_bytes_o      (s1_bytes),
    .s1_pos_o        (s1_pos)
  );

  // Stage 2: compare the snapshot, form start offset and address, and hold
  // a hit in the result register until it is taken.
  bps_match #(
    .MAX_PATTERN_BYTES (MAX_PATTERN_BYTES),
    .OFFSET_BITS       (OFFSET_BITS)
  ) u_match (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s1_valid_i      (s1_valid),
    .s1_ready_o      (s1_ready),
    .s1_bytes_i      (s1_bytes),
    .s1_pos_i        (s1_pos),
    .pattern_i       (pattern_q),
    .len_i           (len_q),
    .base_i          (base_q),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .start_offset_o  (start_offset_o),
    .match_address_o (match_address_o)
  );

endmodule
